[rtl/nsds_pkg.sv]
// Shared widths, codes, pipeline types and step functions of the second difference sensor.
package nsds_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int SUMW      = DW + 3;
  localparam int MAGW      = SUMW - 1;
  localparam int SCALEW    = 32;
  localparam int SCW       = MAGW + SCALEW - FRAC_BITS;
  localparam int HALF      = SCW / 2;
  localparam int HIW       = SCW - HALF;
  localparam int SQW       = 2 * SCW;
  localparam int ACCW      = SQW + 2;
  localparam int ROOTW     = ACCW / 2;
  localparam int REMW      = ROOTW + 2;
  localparam int DENW      = ROOTW + 1;
  localparam int QW        = 31;
  localparam int SAT_SHIFT = QW - FRAC_BITS;
  localparam int EPSW      = 16;
  localparam int MODEW     = 2;
  localparam int CFG_IDXW  = 3;
  localparam int CFG_DW    = 32;
  localparam int IN_DW     = 7 * DW;
  localparam int OUT_DW    = 40;
  localparam int NAXES     = 3;

  typedef enum logic [MODEW-1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_BAD = 2'd2
  } status_e;

  localparam logic [CFG_IDXW-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDXW-1:0] REG_SCALE_X = 3'd1;
  localparam logic [CFG_IDXW-1:0] REG_SCALE_Y = 3'd2;
  localparam logic [CFG_IDXW-1:0] REG_SCALE_Z = 3'd3;
  localparam logic [CFG_IDXW-1:0] REG_EPSILON = 3'd4;

  localparam logic [MODEW-1:0] MODE_3D = 2'd3;

  typedef struct packed {
    logic [ACCW-1:0]  rad;
    logic [REMW-1:0]  rem;
    logic [ROOTW-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DENW-1:0] rem;
    logic [DENW-1:0] den;
    logic [QW-1:0]   low;
    logic [QW-1:0]   quo;
  } dv_t;

  // One-axis values carried past the square roots.
  typedef struct packed {
    logic [MAGW-1:0] num;
    logic [MAGW-1:0] den;
    logic            bad;
  } od_t;

  typedef struct packed {
    logic sat;
    logic bad;
  } flags_t;

  // One digit of the integer square root: two radicand bits per step.
  function automatic sq_t sqrt_step(sq_t s);
    sq_t                 r;
    logic [REMW+1:0]     rr;
    logic [REMW+1:0]     trial;
    begin
      rr    = {s.rem, s.rad[ACCW-1 -: 2]};
      trial = {2'b00, s.root, 2'b01};
      r.rad = {s.rad[ACCW-3:0], 2'b00};
      if (rr >= trial) begin
        r.rem  = REMW'(rr - trial);
        r.root = {s.root[ROOTW-2:0], 1'b1};
      end else begin
        r.rem  = REMW'(rr);
        r.root = {s.root[ROOTW-2:0], 1'b0};
      end
      return r;
    end
  endfunction

  // One quotient bit of restoring division.
  function automatic dv_t div_step(dv_t s);
    dv_t             r;
    logic [DENW:0]   rr;
    begin
      rr    = {s.rem, s.low[QW-1]};
      r.den = s.den;
      r.low = {s.low[QW-2:0], 1'b0};
      if (rr >= {1'b0, s.den}) begin
        r.rem = DENW'(rr - {1'b0, s.den});
        r.quo = {s.quo[QW-2:0], 1'b1};
      end else begin
        r.rem = DENW'(rr);
        r.quo = {s.quo[QW-2:0], 1'b0};
      end
      return r;
    end
  endfunction

endpackage

[rtl/normalized_second_difference_sensor_top.sv]
// Top level of the normalized second difference sensor: one fully pipelined datapath.
//
// Usage: one cell arrives per beat on the s_axis channel (center and its six
// axis neighbours, signed Q16.16) and one result leaves per beat on m_axis
// (sensor value, signed Q16.16, and a status code). The cfg port writes the
// mode, the three axis scales and epsilon; write it only while the pipe is
// empty.
// Throughput is one cell per cycle while m_axis is not held. From input beat to
// output beat a cell passes the sums, scaling and squaring stages, 51 square root
// digit stages (one per root bit), the divisor select and check stages, 31
// restoring division stages (one per quotient bit) and the output register.
// All stages advance together; when the receiver holds m_axis_tready low with
// a beat waiting, the whole pipe holds and s_axis_tready drops, so nothing is
// lost or repeated. Reset empties the pipe and loads the register defaults:
// one axis, unit scales, epsilon of one LSB. There is no clearing pass.
module normalized_second_difference_sensor_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [nsds_pkg::CFG_IDXW-1:0]      cfg_index_i,
  input  logic [nsds_pkg::CFG_DW-1:0]        cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // center, x_left, x_right, y_low, y_high, z_low, z_high; 32 bits each
  input  logic [nsds_pkg::IN_DW-1:0]         s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // sensor_value [31:0], status [33:32], zeros above
  output logic [nsds_pkg::OUT_DW-1:0]        m_axis_tdata
);
  import nsds_pkg::*;

  logic [MODEW-1:0]  mode_q;
  logic [SCALEW-1:0] scale_q [NAXES];
  logic [EPSW-1:0]   eps_q;
  logic              en;
  logic              out_valid_q;
  logic [OUT_DW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODEW'(1);
      scale_q[0] <= SCALEW'(65536);
      scale_q[1] <= SCALEW'(65536);
      scale_q[2] <= SCALEW'(65536);
      eps_q      <= EPSW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODE:    mode_q     <= cfg_data_i[MODEW-1:0];
        REG_SCALE_X: scale_q[0] <= cfg_data_i;
        REG_SCALE_Y: scale_q[1] <= cfg_data_i;
        REG_SCALE_Z: scale_q[2] <= cfg_data_i;
        REG_EPSILON: eps_q      <= cfg_data_i[EPSW-1:0];
        default: ;
      endcase
    end
  end

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage A: exact second differences and weighted sums per axis.
  logic                   va_q;
  logic signed [SUMW-1:0] d_q [NAXES];
  logic signed [SUMW-1:0] s_q [NAXES];
  logic signed [SUMW-1:0] c2;
  logic signed [SUMW-1:0] lft [NAXES];
  logic signed [SUMW-1:0] rgt [NAXES];

  always_comb begin
    c2 = {{(SUMW-DW-1){s_axis_tdata[DW-1]}}, s_axis_tdata[DW-1:0], 1'b0};
    for (int a = 0; a < NAXES; a++) begin
      lft[a] = {{(SUMW-DW){s_axis_tdata[(2*a+2)*DW-1]}}, s_axis_tdata[(2*a+1)*DW +: DW]};
      rgt[a] = {{(SUMW-DW){s_axis_tdata[(2*a+3)*DW-1]}}, s_axis_tdata[(2*a+2)*DW +: DW]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NAXES; a++) begin
        d_q[a] <= rgt[a] - c2 + lft[a];
        s_q[a] <= rgt[a] + c2 + lft[a];
      end
    end
  end

  // Stage B: magnitudes, and the complete one-axis numerator and denominator.
  logic                   vb_q;
  logic [MAGW-1:0]        mag_q [2*NAXES];
  od_t                    odb_q;
  logic signed [SUMW-1:0] s1;

  assign s1 = s_q[0] + SUMW'(eps_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NAXES; a++) begin
        mag_q[a]       <= d_q[a][SUMW-1] ? MAGW'(-d_q[a]) : MAGW'(d_q[a]);
        mag_q[a+NAXES] <= s_q[a][SUMW-1] ? MAGW'(-s_q[a]) : MAGW'(s_q[a]);
      end
      odb_q.num <= d_q[0][SUMW-1] ? MAGW'(-d_q[0]) : MAGW'(d_q[0]);
      odb_q.den <= s1[MAGW-1:0];
      odb_q.bad <= s1[SUMW-1] || (s1 == '0);
    end
  end

  // Stage C: scale by the axis factor, dropping the fraction bits; z is zeroed outside 3D mode.
  logic                     vc_q;
  logic [SCW-1:0]           sc_q [2*NAXES];
  od_t                      odc_q;
  logic [MAGW+SCALEW-1:0]   prod [2*NAXES];

  always_comb begin
    for (int v = 0; v < 2*NAXES; v++) begin
      prod[v] = (MAGW+SCALEW)'(mag_q[v]) * (MAGW+SCALEW)'(scale_q[v % NAXES]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 2*NAXES; v++) begin
        if ((v % NAXES) == NAXES-1 && mode_q != MODE_3D) begin
          sc_q[v] <= '0;
        end else begin
          sc_q[v] <= prod[v][MAGW+SCALEW-1:FRAC_BITS];
        end
      end
      odc_q <= odb_q;
    end
  end

  // Stage D: partial products of each square.
  logic               vd_q;
  logic [2*HIW-1:0]   hh_q [2*NAXES];
  logic [HIW+HALF-1:0] hl_q [2*NAXES];
  logic [2*HALF-1:0]  ll_q [2*NAXES];
  od_t                odd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 2*NAXES; v++) begin
        hh_q[v] <= (2*HIW)'(sc_q[v][SCW-1:HALF]) * (2*HIW)'(sc_q[v][SCW-1:HALF]);
        hl_q[v] <= (HIW+HALF)'(sc_q[v][SCW-1:HALF]) * (HIW+HALF)'(sc_q[v][HALF-1:0]);
        ll_q[v] <= (2*HALF)'(sc_q[v][HALF-1:0]) * (2*HALF)'(sc_q[v][HALF-1:0]);
      end
      odd_q <= odc_q;
    end
  end

  // Stage E: assemble the squares.
  logic           ve_q;
  logic [SQW-1:0] sqr_q [2*NAXES];
  od_t            ode_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 2*NAXES; v++) begin
        sqr_q[v] <= (SQW'(hh_q[v]) << (2*HALF)) + (SQW'(hl_q[v]) << (HALF+1))
                    + SQW'(ll_q[v]);
      end
      ode_q <= odd_q;
    end
  end

  // Stage F: sum of squares over the axes, feeding the root stages.
  logic vsq_q [ROOTW+1];
  sq_t  sqd_q [ROOTW+1];
  sq_t  sqs_q [ROOTW+1];
  od_t  odsq_q [ROOTW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqd_q[0] <= '{rad: ACCW'(sqr_q[0]) + ACCW'(sqr_q[1]) + ACCW'(sqr_q[2]),
                    rem: '0, root: '0};
      sqs_q[0] <= '{rad: ACCW'(sqr_q[3]) + ACCW'(sqr_q[4]) + ACCW'(sqr_q[5]),
                    rem: '0, root: '0};
      odsq_q[0] <= ode_q;
    end
  end

  for (genvar i = 0; i < ROOTW; i++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      if (en) begin
        sqd_q[i+1]  <= sqrt_step(sqd_q[i]);
        sqs_q[i+1]  <= sqrt_step(sqs_q[i]);
        odsq_q[i+1] <= odsq_q[i];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vsq_q[i+1] <= 1'b0;
      end else if (en) begin
        vsq_q[i+1] <= vsq_q[i];
      end
    end
  end

  // Stage G: pick the mode's numerator and denominator.
  logic             vg_q;
  logic [ROOTW-1:0] num_q;
  logic [DENW-1:0]  den_q;
  logic             badg_q;
  logic [DENW-1:0]  den_nd;

  assign den_nd = {1'b0, sqs_q[ROOTW].root} + DENW'(eps_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (mode_q <= MODEW'(1)) begin
        num_q  <= ROOTW'(odsq_q[ROOTW].num);
        den_q  <= DENW'(odsq_q[ROOTW].den);
        badg_q <= odsq_q[ROOTW].bad;
      end else begin
        num_q  <= sqd_q[ROOTW].root;
        den_q  <= den_nd;
        badg_q <= (den_nd == '0);
      end
    end
  end

  // Stage H: saturation check and divider setup, then one quotient bit a stage.
  logic   vdv_q [QW+1];
  dv_t    dv_q  [QW+1];
  flags_t fl_q  [QW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[0].sat <= ({{(DENW+SAT_SHIFT-ROOTW){1'b0}}, num_q} >= {den_q, {SAT_SHIFT{1'b0}}});
      fl_q[0].bad <= badg_q;
      dv_q[0]     <= '{rem: DENW'(num_q >> SAT_SHIFT), den: den_q,
                       low: {num_q[SAT_SHIFT-1:0], {FRAC_BITS{1'b0}}}, quo: '0};
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[i+1] <= div_step(dv_q[i]);
        fl_q[i+1] <= fl_q[i];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vdv_q[i+1] <= 1'b0;
      end else if (en) begin
        vdv_q[i+1] <= vdv_q[i];
      end
    end
  end

  // Output register.
  status_e        status;
  logic [DW-1:0]  value;

  always_comb begin
    if (fl_q[QW].bad) begin
      status = ST_BAD;
      value  = '0;
    end else if (fl_q[QW].sat) begin
      status = ST_SAT;
      value  = {1'b0, {(DW-1){1'b1}}};
    end else begin
      status = ST_OK;
      value  = {1'b0, dv_q[QW].quo};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {{(OUT_DW-DW-MODEW){1'b0}}, status, value};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      vd_q        <= 1'b0;
      ve_q        <= 1'b0;
      vsq_q[0]    <= 1'b0;
      vg_q        <= 1'b0;
      vdv_q[0]    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      va_q        <= s_axis_tvalid;
      vb_q        <= va_q;
      vc_q        <= vb_q;
      vd_q        <= vc_q;
      ve_q        <= vd_q;
      vsq_q[0]    <= ve_q;
      vg_q        <= vsq_q[ROOTW];
      vdv_q[0]    <= vg_q;
      out_valid_q <= vdv_q[QW];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
